// File: hdl/frame_stamped_event_scheduler_defines.svh
// Assertion macros shared by the frame-stamped event scheduler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FRAME_STAMPED_EVENT_SCHEDULER_DEFINES_SVH
`define FRAME_STAMPED_EVENT_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FSES_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define FSES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/fses_pkg.sv
// Package for the frame-stamped event scheduler: defaults, codes and types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fses_pkg;

   localparam int QUEUE_DEPTH_DEF  = 16;
   localparam int FRAME_BITS_DEF   = 32;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam logic [15:0] LATE_WINDOW_RESET = 16'd4096;

   // register indexes on the config port
   localparam logic REG_PLAYING     = 1'b0;
   localparam logic REG_LATE_WINDOW = 1'b1;

   typedef enum logic [1:0] {
      CMD_SCHEDULE   = 2'd0,
      CMD_RENDER     = 2'd1,
      CMD_CLEAR_FROM = 2'd2,
      CMD_CLEAR_ALL  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_RANGE = 2'd0,
      KIND_EVENT = 2'd1,
      KIND_ACK   = 2'd2
   } kind_type;

   // operations on the cell chain
   typedef enum logic [2:0] {
      Q_NONE,
      Q_PUSH,
      Q_POP,
      Q_REQUEUE,
      Q_CLEAR
   } q_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GAP,
      ST_RANGE,
      ST_DISPATCH,
      ST_CLOSE,
      ST_CLEAR
   } state_type;

   // per-cell control: shift from the upper neighbor, or load a new entry
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// File: hdl/fses_cell.sv
// One queue cell: holds a frame stamp and payload, shifts toward the head.
// Depends on fses_pkg for the cell control struct.
`timescale 1ns / 1ps

module fses_cell #(
   parameter int FRAME_BITS   = fses_pkg::FRAME_BITS_DEF,
   parameter int PAYLOAD_BITS = fses_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                      clock,
   input  fses_pkg::cell_ctl_type    ctl,
   input  logic [FRAME_BITS-1:0]     load_frame,
   input  logic [PAYLOAD_BITS-1:0]   load_payload,
   input  logic [FRAME_BITS-1:0]     next_frame,
   input  logic [PAYLOAD_BITS-1:0]   next_payload,
   output logic [FRAME_BITS-1:0]     frame,
   output logic [PAYLOAD_BITS-1:0]   payload
);
   import fses_pkg::*;

   logic [FRAME_BITS-1:0]   frame_ff, frame_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;

   // load wins over shift; otherwise hold
   always_comb begin
      frame_in   = frame_ff;
      payload_in = payload_ff;
      if (ctl.load) begin
         frame_in   = load_frame;
         payload_in = load_payload;
      end else if (ctl.shift) begin
         frame_in   = next_frame;
         payload_in = next_payload;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff   <= frame_in;
      payload_ff <= payload_in;
   end

   assign frame   = frame_ff;
   assign payload = payload_ff;

endmodule

// File: hdl/fses_queue.sv
// Event queue as a chain of cells with the head in cell 0, plus fill count.
// Depends on fses_pkg and fses_cell.
`timescale 1ns / 1ps

module fses_queue #(
   parameter int QUEUE_DEPTH  = fses_pkg::QUEUE_DEPTH_DEF,
   parameter int FRAME_BITS   = fses_pkg::FRAME_BITS_DEF,
   parameter int PAYLOAD_BITS = fses_pkg::PAYLOAD_BITS_DEF,
   localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fses_pkg::q_op_type      op,
   input  logic [FRAME_BITS-1:0]   push_frame,
   input  logic [PAYLOAD_BITS-1:0] push_payload,
   output logic [CW-1:0]           count,
   output logic [FRAME_BITS-1:0]   head_frame,
   output logic [PAYLOAD_BITS-1:0] head_payload
);
   import fses_pkg::*;

   logic [CW-1:0] count_ff, count_in;

   logic [FRAME_BITS-1:0]   cell_frame   [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_payload [QUEUE_DEPTH];
   logic [FRAME_BITS-1:0]   load_frame;
   logic [PAYLOAD_BITS-1:0] load_payload;
   logic                    do_shift;

   // push loads input data; requeue reloads the old head at the tail
   assign do_shift     = (op == Q_POP) || (op == Q_REQUEUE);
   assign load_frame   = (op == Q_REQUEUE) ? cell_frame[0]   : push_frame;
   assign load_payload = (op == Q_REQUEUE) ? cell_payload[0] : push_payload;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctl_type            ctl;
      logic [FRAME_BITS-1:0]   nxt_frame;
      logic [PAYLOAD_BITS-1:0] nxt_payload;

      assign ctl.shift = do_shift;
      assign ctl.load  = ((op == Q_PUSH) && (count_ff == CW'(i))) ||
                         ((op == Q_REQUEUE) && (count_ff == CW'(i + 1)));

      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign nxt_frame   = '0;
         assign nxt_payload = '0;
      end else begin : g_mid
         assign nxt_frame   = cell_frame[i+1];
         assign nxt_payload = cell_payload[i+1];
      end

      fses_cell #(
         .FRAME_BITS   (FRAME_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .load_frame   (load_frame),
         .load_payload (load_payload),
         .next_frame   (nxt_frame),
         .next_payload (nxt_payload),
         .frame        (cell_frame[i]),
         .payload      (cell_payload[i])
      );
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      unique case (op)
         Q_PUSH:    count_in = count_ff + CW'(1);
         Q_POP:     count_in = count_ff - CW'(1);
         Q_CLEAR:   count_in = '0;
         Q_REQUEUE: count_in = count_ff;
         Q_NONE:    count_in = count_ff;
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count        = count_ff;
   assign head_frame   = cell_frame[0];
   assign head_payload = cell_payload[0];

endmodule

// File: hdl/frame_stamped_event_scheduler.sv
// Top level of the frame-stamped event scheduler: sequencer, config, output.
// Depends on fses_pkg, fses_queue (and fses_cell) and the assertion header.
//
//   channel   direction  handshake              words
//   req_*     in         req_valid/req_ready    one command per word
//   rsp_*     out        rsp_valid/rsp_ready    0..33 words per command
//   p*        in/out     psel/penable, pready=1 playing @0x0, late_window @0x4
//
// Schedule: the ack goes straight into the output register. Clear all sends no response.
// Render: each dispatched event passes through scan, gap, range and dispatch; a
//   dropped late event is popped in scan, and an event beyond the block end goes from the gap test to close.
// Clear from frame: the head rotates through the chain, once per queued entry.
// Reset is synchronous; queue comes up empty, no sweep.
// A stalled rsp holds the sequencer; req_ready is low while a command runs.
`timescale 1ns / 1ps

module frame_stamped_event_scheduler #(
   parameter int QUEUE_DEPTH  = fses_pkg::QUEUE_DEPTH_DEF,
   parameter int FRAME_BITS   = fses_pkg::FRAME_BITS_DEF,
   parameter int PAYLOAD_BITS = fses_pkg::PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // commands
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_event_frame,
   input  logic [31:0] req_event_data,
   input  logic        req_batch_last,
   input  logic [15:0] req_block_frames,
   input  logic [31:0] req_clear_frame,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_offset,
   output logic [15:0] rsp_length,
   output logic [31:0] rsp_dispatched_data,
   output logic        rsp_accepted,
   output logic [4:0]  rsp_free_slots,
   output logic        rsp_last,
   // config
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fses_pkg::*;

   `include "frame_stamped_event_scheduler_defines.svh"

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int F  = FRAME_BITS;

   // ---------------- registers ----------------
   state_type          state_ff, state_in;
   logic               playing_ff, playing_in;
   logic [15:0]        late_ff, late_in;
   logic [F-1:0]       position_ff, position_in;
   logic [F-1:0]       start_ff, start_in;
   logic [F-1:0]       point_ff, point_in;
   logic [F-1:0]       eff_ff, eff_in;
   logic [F-1:0]       clr_ff, clr_in;
   logic [15:0]        done_ff, done_in;
   logic [15:0]        block_ff, block_in;
   logic [15:0]        gap_ff, gap_in;
   logic [CW-1:0]      iter_ff, iter_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [15:0]        rsp_offset_ff, rsp_offset_in;
   logic [15:0]        rsp_length_ff, rsp_length_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_acc_ff, rsp_acc_in;
   logic [4:0]         rsp_free_ff, rsp_free_in;
   logic               rsp_last_ff, rsp_last_in;

   // ---------------- queue ----------------
   q_op_type              q_op;
   logic [CW-1:0]         q_count;
   logic [F-1:0]          head_frame;
   logic [PAYLOAD_BITS-1:0] head_payload;
   logic [F-1:0]          ev_frame;
   logic [PAYLOAD_BITS-1:0] ev_data;

   // input fields resized to the internal widths
   logic [63:0] ev_frame_ext, ev_data_ext, clr_ext, head_pay_ext;
   assign ev_frame_ext = 64'(req_event_frame);
   assign ev_data_ext  = 64'(req_event_data);
   assign clr_ext      = 64'(req_clear_frame);
   assign head_pay_ext = 64'(head_payload);
   assign ev_frame     = ev_frame_ext[F-1:0];
   assign ev_data      = ev_data_ext[PAYLOAD_BITS-1:0];

   fses_queue #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .FRAME_BITS   (FRAME_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .op           (q_op),
      .push_frame   (ev_frame),
      .push_payload (ev_data),
      .count        (q_count),
      .head_frame   (head_frame),
      .head_payload (head_payload)
   );

   // ---------------- config port ----------------
   logic cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;
   assign prdata = (paddr[2] == REG_LATE_WINDOW) ? {16'b0, late_ff} : {31'b0, playing_ff};

   always_comb begin
      playing_in = playing_ff;
      late_in    = late_ff;
      if (cfg_wr) begin
         unique case (paddr[2])
            REG_PLAYING:     playing_in = pwdata[0];
            REG_LATE_WINDOW: late_in    = pwdata[15:0];
            default:         playing_in = playing_ff;
         endcase
      end
   end

   // ---------------- datapath helpers ----------------
   logic          out_free;
   logic          req_fire;
   logic          sched_acc;
   logic [CW-1:0] free_cnt;
   logic          late;
   logic [F:0]    late_sum;
   logic          drop;
   logic [F:0]    gap_diff;
   logic [F-1:0]  gap_full;
   logic [15:0]   remain;
   logic          brk;
   logic          keep;
   cmd_type       cmd;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);

   // schedule ack fields
   assign sched_acc = q_count < CW'(QUEUE_DEPTH);
   assign free_cnt  = CW'(QUEUE_DEPTH) - q_count - CW'(sched_acc);

   // late / drop test on the head entry
   assign late     = head_frame < start_ff;
   assign late_sum = {1'b0, head_frame} + (F+1)'(late_ff);
   assign drop     = late && (late_sum < {1'b0, start_ff});

   // gap to the last dispatch point, and the block-end test
   assign gap_diff = {1'b0, eff_ff} - {1'b0, point_ff};
   assign gap_full = gap_diff[F] ? '0 : gap_diff[F-1:0];
   assign remain   = block_ff - done_ff;
   assign brk      = gap_full >= F'(remain);

   // clear-from-frame keeps entries stamped before the clear frame
   assign keep = head_frame < clr_ff;

   // ---------------- sequencer ----------------
   logic rsp_load;

   always_comb begin
      state_in      = state_ff;
      position_in   = position_ff;
      start_in      = start_ff;
      point_in      = point_ff;
      eff_in        = eff_ff;
      clr_in        = clr_ff;
      done_in       = done_ff;
      block_in      = block_ff;
      gap_in        = gap_ff;
      iter_in       = iter_ff;
      q_op          = Q_NONE;
      rsp_load      = 1'b0;
      rsp_kind_in   = KIND_RANGE;
      rsp_offset_in = done_ff;
      rsp_length_in = '0;
      rsp_data_in   = '0;
      rsp_acc_in    = 1'b0;
      rsp_free_in   = '0;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd)
                  CMD_SCHEDULE: begin
                     if (sched_acc) begin
                        q_op = Q_PUSH;
                     end
                     rsp_load      = 1'b1;
                     rsp_kind_in   = KIND_ACK;
                     rsp_offset_in = '0;
                     rsp_acc_in    = sched_acc;
                     rsp_free_in   = 5'(free_cnt);
                     rsp_last_in   = 1'b1;
                  end
                  CMD_RENDER: begin
                     if (playing_ff) begin
                        start_in = position_ff;
                        point_in = position_ff;
                        done_in  = '0;
                        block_in = req_block_frames;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_CLEAR_FROM: begin
                     clr_in  = clr_ext[F-1:0];
                     iter_in = q_count;
                     if (q_count != '0) begin
                        state_in = ST_CLEAR;
                     end
                  end
                  CMD_CLEAR_ALL: begin
                     q_op = Q_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (q_count == '0) begin
               state_in = ST_CLOSE;
            end else if (drop) begin
               q_op = Q_POP;
            end else begin
               eff_in   = late ? start_ff : head_frame;
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            gap_in   = gap_full[15:0];
            state_in = brk ? ST_CLOSE : ST_RANGE;
         end
         ST_RANGE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_kind_in   = KIND_RANGE;
               rsp_length_in = gap_ff;
               done_in       = done_ff + gap_ff;
               point_in      = point_ff + F'(gap_ff);
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_EVENT;
               rsp_data_in = head_pay_ext[31:0];
               q_op        = Q_POP;
               state_in    = ST_SCAN;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_kind_in   = KIND_RANGE;
               rsp_length_in = remain;
               rsp_last_in   = 1'b1;
               position_in   = start_ff + F'(block_ff);
               state_in      = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            q_op    = keep ? Q_REQUEUE : Q_POP;
            iter_in = iter_ff - CW'(1);
            if (iter_ff == CW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register: load a new word or drop the taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         playing_ff   <= 1'b0;
         late_ff      <= LATE_WINDOW_RESET;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         late_ff      <= late_in;
         position_ff  <= position_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      point_ff <= point_in;
      eff_ff   <= eff_in;
      clr_ff   <= clr_in;
      done_ff  <= done_in;
      block_ff <= block_in;
      gap_ff   <= gap_in;
      iter_ff  <= iter_in;
      if (rsp_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_length_ff <= rsp_length_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_acc_ff    <= rsp_acc_in;
         rsp_free_ff   <= rsp_free_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_offset          = rsp_offset_ff;
   assign rsp_length          = rsp_length_ff;
   assign rsp_dispatched_data = rsp_data_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_free_slots      = rsp_free_ff;
   assign rsp_last            = rsp_last_ff;

   // ---------------- checks ----------------
   `FSES_ASSERT_NOW(a_count_bound, 1'b1, q_count <= CW'(QUEUE_DEPTH), "queue count over depth")
   `FSES_ASSERT_NOW(a_ack_last, rsp_valid && (rsp_kind == KIND_ACK), rsp_last, "ack without last")
   `FSES_ASSERT_NEXT(a_close_idle, (state_ff == ST_CLOSE) && out_free, state_ff == ST_IDLE, "close did not end render")
   `FSES_ASSERT_NEXT(a_dispatch_pop, (state_ff == ST_DISPATCH) && out_free, q_count == $past(q_count) - CW'(1), "dispatch did not pop head")

endmodule
